/* src/bfx_pkg.sv */
// bfx_pkg: shared types, field widths, operation and status codes for the
// msb-first bit extractor; used by bfx_exec and msb_first_bit_extractor
`timescale 1ns / 1ps

package bfx_pkg;

    localparam int KIND_W      = 3;
    localparam int BYTE_W      = 8;
    localparam int COUNT_W     = 8;
    localparam int WORD_W      = 32;
    localparam int HELD_OUT_W  = 8;
    localparam int STATUS_W    = 2;

    localparam int DEF_BUF_BITS     = 128;
    localparam int DEF_MAX_GET_BITS = 32;

    localparam logic [KIND_W-1:0] KIND_PUSH  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_GET   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_PUT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERRUN  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_COUNT = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  data_byte;
        logic [COUNT_W-1:0] bit_count;
        logic [WORD_W-1:0]  put_value;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0]     value;
        logic [HELD_OUT_W-1:0] bits_held;
        logic [STATUS_W-1:0]   status;
    } result_t;

endpackage

/* src/bfx_exec.sv */
// bfx_exec: bit store, read position and held count with the combinational
// datapath that executes one item; depends on bfx_pkg
`timescale 1ns / 1ps

module bfx_exec #(
    parameter int BUF_BITS     = bfx_pkg::DEF_BUF_BITS,
    parameter int MAX_GET_BITS = bfx_pkg::DEF_MAX_GET_BITS
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             exec_en,
    input  bfx_pkg::item_t   item,
    output bfx_pkg::result_t result
);

    localparam int PW  = $clog2(BUF_BITS);
    localparam int HW  = $clog2(BUF_BITS + 1);
    localparam int CW  = ((HW > bfx_pkg::COUNT_W) ? HW : bfx_pkg::COUNT_W) + 2;
    localparam int PSW = PW + 2;
    localparam int MW  = MAX_GET_BITS;

    localparam logic [CW-1:0]  BUF_C   = CW'(BUF_BITS);
    localparam logic [CW-1:0]  MAX_C   = CW'(MAX_GET_BITS);
    localparam logic [CW-1:0]  BYTE_C  = CW'(bfx_pkg::BYTE_W);
    localparam logic [PSW-1:0] BUF_P   = PSW'(BUF_BITS);

    logic [BUF_BITS-1:0] store_reg;
    logic [BUF_BITS-1:0] store_next;
    logic [PW-1:0]       rd_pos_reg;
    logic [PW-1:0]       rd_pos_next;
    logic [HW-1:0]       held_reg;
    logic [HW-1:0]       held_next;

    logic [CW-1:0]         n_w;
    logic [CW-1:0]         held_w;
    logic [CW-1:0]         sh_amt;
    logic [2*BUF_BITS-1:0] rd_dbl;
    logic [BUF_BITS-1:0]   rotated;
    logic [MW-1:0]         win;
    logic [MW-1:0]         get_bits;
    logic [MW+bfx_pkg::WORD_W-1:0] get_ext;
    logic [MW+bfx_pkg::WORD_W-1:0] pv_ext;
    logic [MW-1:0]         pv_m;
    logic [MW-1:0]         pv_shift;
    logic [MW-1:0]         put_mask;
    logic [BUF_BITS-1:0]   w_rel;
    logic [BUF_BITS-1:0]   m_rel;
    logic [2*BUF_BITS-1:0] w_dbl;
    logic [2*BUF_BITS-1:0] m_dbl;
    logic [BUF_BITS-1:0]   w_abs;
    logic [BUF_BITS-1:0]   m_abs;
    logic [PSW-1:0]        tail_sum;
    logic [PSW-1:0]        adv_sum;
    logic [PSW-1:0]        back_sum;
    logic [PW-1:0]         tail_pos;
    logic [PW-1:0]         adv_pos;
    logic [PW-1:0]         back_pos;
    logic [PW-1:0]         wr_pos;
    logic                  do_write;
    logic [bfx_pkg::WORD_W-1:0]   value_c;
    logic [bfx_pkg::STATUS_W-1:0] status_c;
    logic [HW+bfx_pkg::HELD_OUT_W-1:0] held_ext;

    always_comb begin
        n_w    = CW'(item.bit_count);
        held_w = CW'(held_reg);

        // window of the store starting at the read position
        rd_dbl  = {store_reg, store_reg} >> rd_pos_reg;
        rotated = rd_dbl[BUF_BITS-1:0];
        for (int i = 0; i < MW; i++) begin
            win[MW-1-i] = rotated[i];
        end
        sh_amt   = MAX_C - n_w;
        get_bits = win >> sh_amt;
        get_ext  = (MW + bfx_pkg::WORD_W)'(get_bits);

        // put-back bits, most significant first
        pv_ext   = (MW + bfx_pkg::WORD_W)'(item.put_value);
        pv_m     = pv_ext[MW-1:0];
        pv_shift = pv_m << sh_amt;
        put_mask = ~({MW{1'b1}} << n_w);

        tail_sum = PSW'(rd_pos_reg) + PSW'(held_reg);
        tail_pos = (tail_sum >= BUF_P) ? PW'(tail_sum - BUF_P) : PW'(tail_sum);
        adv_sum  = PSW'(rd_pos_reg) + PSW'(item.bit_count);
        adv_pos  = (adv_sum >= BUF_P) ? PW'(adv_sum - BUF_P) : PW'(adv_sum);
        back_sum = PSW'(rd_pos_reg) + BUF_P - PSW'(item.bit_count);
        back_pos = (back_sum >= BUF_P) ? PW'(back_sum - BUF_P) : PW'(back_sum);

        w_rel = '0;
        m_rel = '0;
        if (item.kind == bfx_pkg::KIND_PUSH) begin
            for (int i = 0; i < bfx_pkg::BYTE_W; i++) begin
                w_rel[i] = item.data_byte[bfx_pkg::BYTE_W-1-i];
                m_rel[i] = 1'b1;
            end
            wr_pos = tail_pos;
        end else begin
            for (int i = 0; i < MW; i++) begin
                w_rel[i] = pv_shift[MW-1-i];
                m_rel[i] = put_mask[i];
            end
            wr_pos = back_pos;
        end
        w_dbl = {w_rel, w_rel} << wr_pos;
        m_dbl = {m_rel, m_rel} << wr_pos;
        w_abs = w_dbl[2*BUF_BITS-1:BUF_BITS];
        m_abs = m_dbl[2*BUF_BITS-1:BUF_BITS];

        do_write    = 1'b0;
        value_c     = '0;
        status_c    = bfx_pkg::ST_OK;
        rd_pos_next = rd_pos_reg;
        held_next   = held_reg;
        case (item.kind)
            bfx_pkg::KIND_PUSH: begin
                if (held_w + BYTE_C > BUF_C) begin
                    status_c = bfx_pkg::ST_OVERFLOW;
                end else begin
                    do_write  = 1'b1;
                    held_next = HW'(held_w + BYTE_C);
                end
            end
            bfx_pkg::KIND_GET: begin
                if (n_w > MAX_C) begin
                    status_c = bfx_pkg::ST_BAD_COUNT;
                end else if (n_w > held_w) begin
                    status_c = bfx_pkg::ST_UNDERRUN;
                end else begin
                    value_c     = get_ext[bfx_pkg::WORD_W-1:0];
                    rd_pos_next = adv_pos;
                    held_next   = HW'(held_w - n_w);
                end
            end
            bfx_pkg::KIND_SKIP: begin
                if (n_w > BUF_C) begin
                    status_c = bfx_pkg::ST_BAD_COUNT;
                end else if (n_w > held_w) begin
                    status_c = bfx_pkg::ST_UNDERRUN;
                end else begin
                    rd_pos_next = adv_pos;
                    held_next   = HW'(held_w - n_w);
                end
            end
            bfx_pkg::KIND_PUT: begin
                if (n_w > MAX_C) begin
                    status_c = bfx_pkg::ST_BAD_COUNT;
                end else if (held_w + n_w > BUF_C) begin
                    status_c = bfx_pkg::ST_OVERFLOW;
                end else begin
                    do_write    = 1'b1;
                    rd_pos_next = back_pos;
                    held_next   = HW'(held_w + n_w);
                end
            end
            bfx_pkg::KIND_CLEAR: begin
                rd_pos_next = '0;
                held_next   = '0;
            end
            default: begin
                status_c = bfx_pkg::ST_BAD_COUNT;
            end
        endcase

        store_next = do_write ? ((store_reg & ~m_abs) | (w_abs & m_abs)) : store_reg;

        held_ext         = (HW + bfx_pkg::HELD_OUT_W)'(held_next);
        result.value     = value_c;
        result.bits_held = held_ext[bfx_pkg::HELD_OUT_W-1:0];
        result.status    = status_c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_pos_reg <= '0;
            held_reg   <= '0;
        end else if (exec_en) begin
            rd_pos_reg <= rd_pos_next;
            held_reg   <= held_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (exec_en) begin
            store_reg <= store_next;
        end
    end

endmodule

/* src/msb_first_bit_extractor.sv */
// The block takes one item per cycle for as long as the result side keeps
// taking transfers: an input register and a result register bracket a single
// pass through the bit store, which is rotated, read and written between the
// two registers.
// Every item gives exactly one result; an item that fails (status not ok)
// leaves the store, read position and held count as they were.
//
// msb_first_bit_extractor: stream top level with input and result registers;
// depends on bfx_pkg and bfx_exec
`timescale 1ns / 1ps

module msb_first_bit_extractor #(
    parameter int BUF_BITS     = bfx_pkg::DEF_BUF_BITS,
    parameter int MAX_GET_BITS = bfx_pkg::DEF_MAX_GET_BITS
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // data_byte[7:0], bit_count[15:8], put_value[47:16]
    input  logic [2:0]  s_tuser,   // kind[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // value[31:0], bits_held[39:32], status[41:40], zero
);

    logic             in_valid_reg;
    bfx_pkg::item_t   in_item_reg;
    logic             m_valid_reg;
    bfx_pkg::result_t res_reg;
    bfx_pkg::result_t res_next;
    logic             adv;
    logic             fire;

    assign adv      = !m_valid_reg || m_tready;
    assign fire     = in_valid_reg && adv;
    assign s_tready = !in_valid_reg || adv;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, res_reg.status, res_reg.bits_held, res_reg.value};

    bfx_exec #(
        .BUF_BITS     (BUF_BITS),
        .MAX_GET_BITS (MAX_GET_BITS)
    ) u_exec (
        .aclk    (aclk),
        .aresetn (aresetn),
        .exec_en (fire),
        .item    (in_item_reg),
        .result  (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (adv) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg.kind      <= s_tuser;
            in_item_reg.data_byte <= s_tdata[7:0];
            in_item_reg.bit_count <= s_tdata[15:8];
            in_item_reg.put_value <= s_tdata[47:16];
        end
        if (fire) begin
            res_reg <= res_next;
        end
    end

endmodule
